// File: hdl/rdcm_pkg.sv
// ----------------------------------------------------------------------------
// rdcm_pkg
// types, codes and reset values shared by the duty-cycling mac controller
// ----------------------------------------------------------------------------
package rdcm_pkg;

    localparam int unsigned LONG_W  = 20;
    localparam int unsigned SHORT_W = 16;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned PTMR_W  = 21;
    localparam int unsigned CFG_IDX_W = 3;

    localparam int unsigned STROBE_CCA_MULT = 2;

    localparam logic [LONG_W-1:0]  CHECK_PERIOD_RST     = 20'd125000;
    localparam logic [SHORT_W-1:0] CCA_SPACING_RST      = 16'd500;
    localparam logic [COUNT_W-1:0] CCA_COUNT_RST        = 8'd2;
    localparam logic [SHORT_W-1:0] SILENCE_POLL_RST     = 16'd500;
    localparam logic [LONG_W-1:0]  SILENCE_WAIT_RST     = 20'd10000;
    localparam logic [LONG_W-1:0]  LISTEN_WINDOW_RST    = 20'd10000;
    localparam logic [LONG_W-1:0]  RECEIVE_TIMEOUT_RST  = 20'd10000;
    localparam logic [SHORT_W-1:0] RESEND_GAP_RST       = 16'd500;

    typedef enum logic [2:0] {
        REG_CHECK_PERIOD    = 3'd0,
        REG_CCA_SPACING     = 3'd1,
        REG_CCA_COUNT       = 3'd2,
        REG_SILENCE_POLL    = 3'd3,
        REG_SILENCE_WAIT    = 3'd4,
        REG_LISTEN_WINDOW   = 3'd5,
        REG_RECEIVE_TIMEOUT = 3'd6,
        REG_RESEND_GAP      = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        FUNC_TICK     = 3'd0,
        FUNC_RX_BEGIN = 3'd1,
        FUNC_RX_END   = 3'd2,
        FUNC_TX_REQ   = 3'd3,
        FUNC_TX_STAT  = 3'd4,
        FUNC_SET_MODE = 3'd5
    } func_t;

    typedef enum logic [1:0] {
        TXR_OK    = 2'd0,
        TXR_NOACK = 2'd1,
        TXR_ERROR = 2'd2
    } tx_res_t;

    typedef enum logic [2:0] {
        PH_SLEEP  = 3'd0,
        PH_SCAN   = 3'd1,
        PH_SEEK   = 3'd2,
        PH_LISTEN = 3'd3,
        PH_RECV   = 3'd4,
        PH_TX     = 3'd5,
        PH_ON     = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_SLEEP   = 3'd1,
        CMD_STANDBY = 3'd2,
        CMD_LISTEN  = 3'd3,
        CMD_TX      = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        RS_SLEEP   = 2'd0,
        RS_STANDBY = 2'd1,
        RS_LISTEN  = 2'd2
    } radio_state_t;

    typedef enum logic [1:0] {
        CAUSE_NONE  = 2'd0,
        CAUSE_RECV  = 2'd1,
        CAUSE_NOISE = 2'd2
    } cause_t;

    typedef struct packed {
        logic [LONG_W-1:0]  check_period;
        logic [SHORT_W-1:0] cca_spacing;
        logic [COUNT_W-1:0] cca_count;
        logic [SHORT_W-1:0] silence_poll_interval;
        logic [LONG_W-1:0]  silence_wait_timeout;
        logic [LONG_W-1:0]  listen_window;
        logic [LONG_W-1:0]  receive_timeout;
        logic [SHORT_W-1:0] resend_gap;
    } cfg_t;

    typedef struct packed {
        logic [2:0] func;
        logic       cca_idle;
        logic [1:0] tx_result;
        logic       is_broadcast;
        logic       always_on_value;
    } in_item_t;

    typedef struct packed {
        logic [2:0] radio_command;
        logic [2:0] phase;
        logic       sample_used;
        logic [1:0] sleep_cause;
        logic       tx_done;
        logic       tx_acked;
        logic       always_on;
    } out_item_t;

    function automatic logic [2:0] radio_cmd(input radio_state_t rs);
        return 3'({1'b0, rs} + 3'd1);
    endfunction

endpackage

// File: hdl/radio_duty_cycle_mac_controller.sv
// ----------------------------------------------------------------------------
// radio_duty_cycle_mac_controller
// low-power-listening duty-cycling sequencer for a radio mac
// ----------------------------------------------------------------------------
// Takes one event per transfer (timer tick with its clear-channel sample, rx
// begin/end, tx request, tx status, set mode) and returns exactly one result
// per event: radio command, phase, sample use, fast-sleep cause, strobe
// completion and always-on readback. One event is taken every clock cycle while
// the result stream is not held; each result is offered on the result stream
// after it passes an input register and then a result register, with the whole
// state update done combinationally between them. A result held by the receiver
// stalls the input once both registers are full. Configuration writes are
// taken in any cycle and are meant to happen while no event is in flight.
module radio_duty_cycle_mac_controller
    import rdcm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // config write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LONG_W-1:0]    cfg_data,
    // event stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,  // cca_idle, tx_result[1:0], is_broadcast,
                                           // always_on_value, zero pad
    input  logic [2:0]           s_tuser,  // func
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata   // radio_command[2:0], phase[2:0], sample_used,
                                           // sleep_cause[1:0], tx_done, tx_acked, always_on, zero pad
);

    cfg_t      cfg;
    in_item_t  in_item_reg;
    logic      in_valid_reg;
    out_item_t out_item_reg;
    logic      out_valid_reg;
    out_item_t step_result;
    logic      advance;

    rdcm_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.func            <= s_tuser;
            in_item_reg.cca_idle        <= s_tdata[0];
            in_item_reg.tx_result       <= s_tdata[2:1];
            in_item_reg.is_broadcast    <= s_tdata[3];
            in_item_reg.always_on_value <= s_tdata[4];
        end
    end

    rdcm_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000,
                       out_item_reg.always_on,
                       out_item_reg.tx_acked,
                       out_item_reg.tx_done,
                       out_item_reg.sleep_cause,
                       out_item_reg.sample_used,
                       out_item_reg.phase,
                       out_item_reg.radio_command};

endmodule

// File: hdl/rdcm_cfg_regs.sv
// ----------------------------------------------------------------------------
// rdcm_cfg_regs
// configuration register file written through the index/data channel
// ----------------------------------------------------------------------------
module rdcm_cfg_regs
    import rdcm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LONG_W-1:0]    cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_CHECK_PERIOD:    cfg_next.check_period          = cfg_data;
                REG_CCA_SPACING:     cfg_next.cca_spacing           = cfg_data[SHORT_W-1:0];
                REG_CCA_COUNT:       cfg_next.cca_count             = cfg_data[COUNT_W-1:0];
                REG_SILENCE_POLL:    cfg_next.silence_poll_interval = cfg_data[SHORT_W-1:0];
                REG_SILENCE_WAIT:    cfg_next.silence_wait_timeout  = cfg_data;
                REG_LISTEN_WINDOW:   cfg_next.listen_window         = cfg_data;
                REG_RECEIVE_TIMEOUT: cfg_next.receive_timeout       = cfg_data;
                REG_RESEND_GAP:      cfg_next.resend_gap            = cfg_data[SHORT_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.check_period          <= CHECK_PERIOD_RST;
            cfg_reg.cca_spacing           <= CCA_SPACING_RST;
            cfg_reg.cca_count             <= CCA_COUNT_RST;
            cfg_reg.silence_poll_interval <= SILENCE_POLL_RST;
            cfg_reg.silence_wait_timeout  <= SILENCE_WAIT_RST;
            cfg_reg.listen_window         <= LISTEN_WINDOW_RST;
            cfg_reg.receive_timeout       <= RECEIVE_TIMEOUT_RST;
            cfg_reg.resend_gap            <= RESEND_GAP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: hdl/rdcm_core.sv
// ----------------------------------------------------------------------------
// rdcm_core
// sequencer state and the combinational update for one registered item
// ----------------------------------------------------------------------------
module rdcm_core
    import rdcm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step_en,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    phase_t               cur_phase_reg,     cur_phase_next;
    logic [LONG_W-1:0]    period_count_reg,  period_count_next;
    logic [PTMR_W-1:0]    phase_timer_reg,   phase_timer_next;
    logic [SHORT_W-1:0]   step_timer_reg,    step_timer_next;
    logic [COUNT_W-1:0]   scans_left_reg,    scans_left_next;
    logic                 strobe_bcast_reg,  strobe_bcast_next;
    logic                 resend_pend_reg,   resend_pend_next;
    logic                 await_stat_reg,    await_stat_next;
    radio_state_t         saved_rs_reg,      saved_rs_next;
    logic                 check_pend_reg,    check_pend_next;
    logic                 always_on_reg,     always_on_next;

    logic                 busy_tx;
    logic                 pt_expired;
    logic [PTMR_W-1:0]    pt_dec;
    logic                 st_expired;
    logic [SHORT_W-1:0]   st_dec;
    logic [LONG_W-1:0]    pc_inc;
    logic                 period_hit;
    logic [PTMR_W-1:0]    strobe_len;

    assign busy_tx    = (cur_phase_reg == PH_TX);
    assign pt_expired = (phase_timer_reg <= PTMR_W'(1));
    assign pt_dec     = pt_expired ? '0 : phase_timer_reg - PTMR_W'(1);
    assign st_expired = (step_timer_reg <= SHORT_W'(1));
    assign st_dec     = st_expired ? '0 : step_timer_reg - SHORT_W'(1);
    assign pc_inc     = period_count_reg + LONG_W'(1);
    assign period_hit = (pc_inc >= cfg.check_period);
    assign strobe_len = PTMR_W'(cfg.check_period)
                      + PTMR_W'(PTMR_W'(cfg.cca_spacing) * PTMR_W'(STROBE_CCA_MULT));

    always_comb
    begin
        cur_phase_next    = cur_phase_reg;
        period_count_next = period_count_reg;
        phase_timer_next  = phase_timer_reg;
        step_timer_next   = step_timer_reg;
        scans_left_next   = scans_left_reg;
        strobe_bcast_next = strobe_bcast_reg;
        resend_pend_next  = resend_pend_reg;
        await_stat_next   = await_stat_reg;
        saved_rs_next     = saved_rs_reg;
        check_pend_next   = check_pend_reg;
        always_on_next    = always_on_reg;

        result.radio_command = CMD_NONE;
        result.sample_used   = 1'b0;
        result.sleep_cause   = CAUSE_NONE;
        result.tx_done       = 1'b0;
        result.tx_acked      = 1'b0;

        unique case (item.func)
            FUNC_TICK:
            begin
                if (busy_tx)
                begin
                    if (!always_on_reg)
                    begin
                        period_count_next = period_hit ? '0 : pc_inc;
                        if (period_hit)
                        begin
                            check_pend_next = 1'b1;
                        end
                    end
                    phase_timer_next = pt_dec;
                    if (pt_expired)
                    begin
                        result.tx_done       = 1'b1;
                        result.radio_command = radio_cmd(saved_rs_reg);
                        cur_phase_next       = always_on_reg ? PH_ON : PH_SLEEP;
                        resend_pend_next     = 1'b0;
                        await_stat_next      = 1'b0;
                        phase_timer_next     = '0;
                        step_timer_next      = '0;
                    end
                    else if (resend_pend_reg)
                    begin
                        step_timer_next = st_dec;
                        if (st_expired)
                        begin
                            resend_pend_next     = 1'b0;
                            await_stat_next      = 1'b1;
                            result.radio_command = CMD_TX;
                        end
                    end
                end
                else if (!always_on_reg)
                begin
                    period_count_next = period_hit ? '0 : pc_inc;
                    if (check_pend_reg || period_hit)
                    begin
                        check_pend_next      = 1'b0;
                        saved_rs_next        = RS_STANDBY;
                        result.radio_command = CMD_STANDBY;
                        cur_phase_next       = PH_SCAN;
                        scans_left_next      = cfg.cca_count;
                        step_timer_next      = SHORT_W'(1);
                        phase_timer_next     = '0;
                    end
                    else
                    begin
                        unique case (cur_phase_reg)
                            PH_SCAN:
                            begin
                                step_timer_next = st_dec;
                                if (st_expired)
                                begin
                                    result.sample_used = 1'b1;
                                    if (!item.cca_idle)
                                    begin
                                        cur_phase_next   = PH_SEEK;
                                        phase_timer_next = PTMR_W'(cfg.silence_wait_timeout);
                                        step_timer_next  = SHORT_W'(1);
                                    end
                                    else if (scans_left_reg <= COUNT_W'(1))
                                    begin
                                        scans_left_next      = '0;
                                        saved_rs_next        = RS_SLEEP;
                                        result.radio_command = CMD_SLEEP;
                                        cur_phase_next       = PH_SLEEP;
                                        phase_timer_next     = '0;
                                        step_timer_next      = '0;
                                    end
                                    else
                                    begin
                                        scans_left_next = scans_left_reg - COUNT_W'(1);
                                        step_timer_next = cfg.cca_spacing;
                                    end
                                end
                            end
                            PH_SEEK:
                            begin
                                if (pt_expired)
                                begin
                                    saved_rs_next        = RS_SLEEP;
                                    result.radio_command = CMD_SLEEP;
                                    cur_phase_next       = PH_SLEEP;
                                    phase_timer_next     = '0;
                                    step_timer_next      = '0;
                                    result.sleep_cause   = CAUSE_NOISE;
                                end
                                else
                                begin
                                    phase_timer_next = pt_dec;
                                    step_timer_next  = st_dec;
                                    if (st_expired)
                                    begin
                                        result.sample_used = 1'b1;
                                        if (item.cca_idle)
                                        begin
                                            saved_rs_next        = RS_LISTEN;
                                            result.radio_command = CMD_LISTEN;
                                            cur_phase_next       = PH_LISTEN;
                                            phase_timer_next     =
                                                PTMR_W'(cfg.listen_window);
                                        end
                                        else
                                        begin
                                            step_timer_next = cfg.silence_poll_interval;
                                        end
                                    end
                                end
                            end
                            PH_LISTEN, PH_RECV:
                            begin
                                phase_timer_next = pt_dec;
                                if (pt_expired)
                                begin
                                    saved_rs_next        = RS_SLEEP;
                                    result.radio_command = CMD_SLEEP;
                                    cur_phase_next       = PH_SLEEP;
                                    phase_timer_next     = '0;
                                    step_timer_next      = '0;
                                    result.sleep_cause   = (cur_phase_reg == PH_RECV)
                                                         ? CAUSE_RECV : CAUSE_NOISE;
                                end
                            end
                            default:
                            begin
                                cur_phase_next = cur_phase_reg;
                            end
                        endcase
                    end
                end
            end
            FUNC_RX_BEGIN:
            begin
                if (!always_on_reg && !busy_tx)
                begin
                    cur_phase_next   = PH_RECV;
                    phase_timer_next = PTMR_W'(cfg.receive_timeout);
                    step_timer_next  = '0;
                end
            end
            FUNC_RX_END:
            begin
                if (!always_on_reg && !busy_tx)
                begin
                    saved_rs_next        = RS_SLEEP;
                    result.radio_command = CMD_SLEEP;
                    cur_phase_next       = PH_SLEEP;
                    phase_timer_next     = '0;
                    step_timer_next      = '0;
                end
            end
            FUNC_TX_REQ:
            begin
                if (!busy_tx)
                begin
                    cur_phase_next       = PH_TX;
                    phase_timer_next     = strobe_len;
                    step_timer_next      = '0;
                    strobe_bcast_next    = item.is_broadcast;
                    resend_pend_next     = 1'b0;
                    await_stat_next      = 1'b1;
                    result.radio_command = CMD_TX;
                end
            end
            FUNC_TX_STAT:
            begin
                if (busy_tx && await_stat_reg)
                begin
                    await_stat_next = 1'b0;
                    if ((item.tx_result == TXR_OK) && !strobe_bcast_reg)
                    begin
                        result.tx_done       = 1'b1;
                        result.tx_acked      = 1'b1;
                        result.radio_command = radio_cmd(saved_rs_reg);
                        cur_phase_next       = always_on_reg ? PH_ON : PH_SLEEP;
                        resend_pend_next     = 1'b0;
                        phase_timer_next     = '0;
                        step_timer_next      = '0;
                    end
                    else if ((item.tx_result == TXR_OK) && (cfg.resend_gap != '0))
                    begin
                        resend_pend_next = 1'b1;
                        step_timer_next  = cfg.resend_gap;
                    end
                    else
                    begin
                        await_stat_next      = 1'b1;
                        result.radio_command = CMD_TX;
                    end
                end
            end
            FUNC_SET_MODE:
            begin
                if (!busy_tx)
                begin
                    always_on_next    = item.always_on_value;
                    period_count_next = '0;
                    phase_timer_next  = '0;
                    step_timer_next   = '0;
                    scans_left_next   = '0;
                    if (item.always_on_value)
                    begin
                        check_pend_next      = 1'b0;
                        cur_phase_next       = PH_ON;
                        saved_rs_next        = RS_LISTEN;
                        result.radio_command = CMD_LISTEN;
                    end
                    else
                    begin
                        check_pend_next = 1'b1;
                        cur_phase_next  = PH_SLEEP;
                    end
                end
            end
            default:
            begin
                cur_phase_next = cur_phase_reg;
            end
        endcase

        result.phase     = cur_phase_next;
        result.always_on = always_on_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_phase_reg    <= PH_SLEEP;
            period_count_reg <= '0;
            phase_timer_reg  <= '0;
            step_timer_reg   <= '0;
            scans_left_reg   <= '0;
            strobe_bcast_reg <= 1'b0;
            resend_pend_reg  <= 1'b0;
            await_stat_reg   <= 1'b0;
            saved_rs_reg     <= RS_SLEEP;
            check_pend_reg   <= 1'b1;
            always_on_reg    <= 1'b0;
        end
        else if (step_en)
        begin
            cur_phase_reg    <= cur_phase_next;
            period_count_reg <= period_count_next;
            phase_timer_reg  <= phase_timer_next;
            step_timer_reg   <= step_timer_next;
            scans_left_reg   <= scans_left_next;
            strobe_bcast_reg <= strobe_bcast_next;
            resend_pend_reg  <= resend_pend_next;
            await_stat_reg   <= await_stat_next;
            saved_rs_reg     <= saved_rs_next;
            check_pend_reg   <= check_pend_next;
            always_on_reg    <= always_on_next;
        end
    end

endmodule
